>>> rtl/keypad_code_lock_menu_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keypad code lock
// Shared concurrent-check shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_MENU_MACROS_SVH
`define KEYPAD_CODE_LOCK_MENU_MACROS_SVH

// same-cycle implication
`define KCLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kclm_pkg.sv
// ---------------------------------------------------------------------------
// kclm_pkg
// Types, codes and helper functions for the keypad code lock.
// ---------------------------------------------------------------------------
package kclm_pkg;

  localparam logic [3:0] DIGIT_BLANK = 4'd10;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;

  // key codes
  localparam logic [1:0] KEY_K1    = 2'd0;
  localparam logic [1:0] KEY_K2    = 2'd1;
  localparam logic [1:0] KEY_K3    = 2'd2;
  localparam logic [1:0] KEY_ENTER = 2'd3;

  // screen codes as seen on the result channel
  localparam logic [1:0] SCREEN_SPLASH = 2'd0;
  localparam logic [1:0] SCREEN_CODE   = 2'd1;
  localparam logic [1:0] SCREEN_CTRL   = 2'd2;
  localparam logic [1:0] SCREEN_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_CODE_FIRST  = 2'd0;
  localparam logic [1:0] REG_CODE_SECOND = 2'd1;
  localparam logic [1:0] REG_CODE_THIRD  = 2'd2;
  localparam logic [1:0] REG_ERROR_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    ST_SPLASH = 3'b001,
    ST_CODE   = 3'b010,
    ST_CTRL   = 3'b100
  } screen_state_t;

  typedef struct packed {
    logic [3:0] code_first;
    logic [3:0] code_second;
    logic [3:0] code_third;
    logic [2:0] error_limit;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] key_id;
  } key_item_t;

  // blank steps to 0, 9 wraps to 0
  function automatic logic [3:0] step_digit(input logic [3:0] d);
    logic [3:0] r;
    if (d >= DIGIT_MAX) r = 4'd0;
    else r = d + 4'd1;
    return r;
  endfunction

  function automatic logic digit_match(input logic [3:0] d, input logic [3:0] code);
    return (d != DIGIT_BLANK) && (d == code);
  endfunction

endpackage

>>> rtl/kclm_if.sv
// ---------------------------------------------------------------------------
// Channel interfaces for the keypad code lock
// Key press requests, result requests and configuration writes.
// ---------------------------------------------------------------------------
interface kclm_key_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_id;

  modport source (output valid, output key_id, input ready);
  modport sink   (input valid, input key_id, output ready);
endinterface

interface kclm_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] screen;
  logic       page;
  logic       led_on;
  logic       beeper_on;
  logic [3:0] digit_first;
  logic [3:0] digit_second;
  logic [3:0] digit_third;
  logic       alarm_pulse;
  logic [2:0] error_count;

  modport source (output valid, output screen, output page, output led_on,
                  output beeper_on, output digit_first, output digit_second,
                  output digit_third, output alarm_pulse, output error_count,
                  input ready);
  modport sink   (input valid, input screen, input page, input led_on,
                  input beeper_on, input digit_first, input digit_second,
                  input digit_third, input alarm_pulse, input error_count,
                  output ready);
endinterface

interface kclm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/kclm_cfg_regs.sv
// ---------------------------------------------------------------------------
// kclm_cfg_regs
// Code and error-limit registers, written through the configuration port.
// ---------------------------------------------------------------------------
module kclm_cfg_regs
  import kclm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kclm_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.code_first  <= 4'd1;
      regs.code_second <= 4'd2;
      regs.code_third  <= 4'd3;
      regs.error_limit <= 3'd3;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CODE_FIRST:  regs.code_first  <= cfg.data;
        REG_CODE_SECOND: regs.code_second <= cfg.data;
        REG_CODE_THIRD:  regs.code_third  <= cfg.data;
        REG_ERROR_LIMIT: regs.error_limit <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/kclm_in_reg.sv
// ---------------------------------------------------------------------------
// kclm_in_reg
// Input register for key press requests; refills in the cycle it drains.
// ---------------------------------------------------------------------------
module kclm_in_reg
  import kclm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kclm_key_if.sink   keys,
  input  logic       take,
  output key_item_t  item
);

  logic       valid;
  logic [1:0] key_id;

  assign keys.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (keys.ready) begin
      valid <= keys.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (keys.ready && keys.valid) begin
      key_id <= keys.key_id;
    end
  end

  assign item.valid  = valid;
  assign item.key_id = key_id;

endmodule

>>> rtl/kclm_core.sv
// ---------------------------------------------------------------------------
// kclm_core
// Menu state machine and code check. The state registers double as the
// result register: they only move when the previous result is taken.
// ---------------------------------------------------------------------------
module kclm_core
  import kclm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  input  key_item_t  item,
  output logic       take,
  kclm_res_if.source res
);

  screen_state_t state, state_next;
  logic          page, page_next;
  logic          led, led_next;
  logic          beeper, beeper_next;
  logic [3:0]    digits [3];
  logic [3:0]    digits_next [3];
  logic [2:0]    wrong_count, wrong_count_next;
  logic          alarm, alarm_next;
  logic          out_valid;
  logic [2:0]    bumped;
  logic          code_ok;

  assign take = item.valid && (!out_valid || res.ready);

  assign bumped  = wrong_count + 3'd1;
  assign code_ok = digit_match(digits[0], regs.code_first) &&
                   digit_match(digits[1], regs.code_second) &&
                   digit_match(digits[2], regs.code_third);

  always_comb begin
    state_next       = state;
    page_next        = page;
    led_next         = led;
    beeper_next      = beeper;
    digits_next      = digits;
    wrong_count_next = wrong_count;
    alarm_next       = 1'b0;
    case (state)
      ST_SPLASH: begin
        if (item.key_id == KEY_ENTER) state_next = ST_CODE;
      end
      ST_CODE: begin
        if (item.key_id == KEY_ENTER) begin
          if (code_ok) begin
            state_next = ST_CTRL;
          end else if (bumped >= regs.error_limit) begin
            alarm_next       = 1'b1;
            wrong_count_next = 3'd0;
          end else begin
            wrong_count_next = bumped;
          end
          digits_next[0] = DIGIT_BLANK;
          digits_next[1] = DIGIT_BLANK;
          digits_next[2] = DIGIT_BLANK;
        end else begin
          digits_next[item.key_id] = step_digit(digits[item.key_id]);
        end
      end
      ST_CTRL: begin
        case (item.key_id)
          KEY_K1:    led_next    = !led;
          KEY_K2:    beeper_next = !beeper;
          KEY_ENTER: page_next   = !page;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SPLASH;
      page        <= 1'b0;
      led         <= 1'b0;
      beeper      <= 1'b0;
      digits[0]   <= DIGIT_BLANK;
      digits[1]   <= DIGIT_BLANK;
      digits[2]   <= DIGIT_BLANK;
      wrong_count <= 3'd0;
      alarm       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        state       <= state_next;
        page        <= page_next;
        led         <= led_next;
        beeper      <= beeper_next;
        digits      <= digits_next;
        wrong_count <= wrong_count_next;
        alarm       <= alarm_next;
        out_valid   <= 1'b1;
      end else if (res.ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_comb begin
    case (state)
      ST_SPLASH: res.screen = SCREEN_SPLASH;
      ST_CODE:   res.screen = SCREEN_CODE;
      ST_CTRL:   res.screen = SCREEN_CTRL;
      default:   res.screen = SCREEN_NONE;
    endcase
  end

  assign res.valid        = out_valid;
  assign res.page         = page;
  assign res.led_on       = led;
  assign res.beeper_on    = beeper;
  assign res.digit_first  = digits[0];
  assign res.digit_second = digits[1];
  assign res.digit_third  = digits[2];
  assign res.alarm_pulse  = alarm;
  assign res.error_count  = wrong_count;

endmodule

>>> rtl/keypad_code_lock_menu.sv
// ---------------------------------------------------------------------------
// keypad_code_lock_menu
// Three-digit code lock with splash, code-entry and control screens.
//
//   channel   dir   width  contents
//   keys      in    2      key_id
//   results   out   21     screen, page, led/beeper, three digits, alarm, count
//   cfg       in    2+4    register index, write data
//
// One key request per cycle sustained while results are taken; each request
// is registered in the input register, then in the state/result registers.
// Synchronous reset returns to the splash screen with blank digits and the
// default code 1-2-3, limit 3. A stalled result holds the state; the input
// register still takes one more request meanwhile. Config writes never stall.
// ---------------------------------------------------------------------------
`include "keypad_code_lock_menu_macros.svh"

module keypad_code_lock_menu
  import kclm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kclm_key_if.sink   keys,
  kclm_res_if.source results,
  kclm_cfg_if.sink   cfg
);

  cfg_t      regs;
  key_item_t item;
  logic      take;
  logic      alarm_seen;
  logic      splash_seen;
  logic      digits_blank;

  kclm_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  kclm_in_reg u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .keys (keys),
    .take (take),
    .item (item)
  );

  kclm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .item (item),
    .take (take),
    .res  (results)
  );

  assign alarm_seen   = results.valid && results.alarm_pulse;
  assign splash_seen  = results.valid && (results.screen == SCREEN_SPLASH);
  assign digits_blank = (results.digit_first == DIGIT_BLANK) &&
                        (results.digit_second == DIGIT_BLANK) &&
                        (results.digit_third == DIGIT_BLANK);

  // an alarm always restarts the wrong-entry count
  `KCLM_ASSERT_IMP(a_alarm_clears, alarm_seen, results.error_count == 3'd0, "alarm with count")

  // alarms only come from a failed code entry
  `KCLM_ASSERT_IMP(a_alarm_screen, alarm_seen, results.screen == SCREEN_CODE, "alarm off code screen")

  // splash screen shows blank digits
  `KCLM_ASSERT_IMP(a_splash_blank, splash_seen, digits_blank, "digits set on splash screen")

  // once unlocked, the control screen is kept
  `KCLM_ASSERT_NXT(a_ctrl_sticky, results.screen == SCREEN_CTRL, results.screen == SCREEN_CTRL, "left control")

endmodule

>>> tb/sv/keypad_code_lock_menu_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// keypad_code_lock_menu_tb
// Drives key press requests into the code lock and checks every result
// request against a cycle-free model of the screens, digits and error
// counter. The code and limit registers are reprogrammed between phases.
// ---------------------------------------------------------------------------
module keypad_code_lock_menu_tb;
  import kclm_pkg::*;

  typedef struct packed {
    logic [1:0] screen;
    logic       page;
    logic       led_on;
    logic       beeper_on;
    logic [3:0] digit_first;
    logic [3:0] digit_second;
    logic [3:0] digit_third;
    logic       alarm_pulse;
    logic [2:0] error_count;
  } lock_view_t;

  localparam int unsigned TOTAL_PRESSES = 1170;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  kclm_key_if key_ch ();
  kclm_res_if res_ch ();
  kclm_cfg_if cfg_ch ();

  keypad_code_lock_menu dut (
    .clk     (clk),
    .rst     (rst),
    .keys    (key_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // model state and programmed code
  logic [3:0] code_val [3];
  logic [2:0] limit_val;
  logic [1:0] scr;
  logic       pg;
  logic       led;
  logic       beep;
  logic [3:0] digs [3];
  logic [2:0] wrongs;
  logic [1:0] digit_key [3];

  lock_view_t  pending_views[$];
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned presses;

  function automatic lock_view_t apply_key(input logic [1:0] key);
    lock_view_t v;
    logic [2:0] n;
    logic       hit;
    logic       alarm;
    alarm = 1'b0;
    case (scr)
      SCREEN_SPLASH: begin
        if (key == KEY_ENTER) scr = SCREEN_CODE;
      end
      SCREEN_CODE: begin
        if (key != KEY_ENTER) begin
          digs[key] = (digs[key] >= 4'd9) ? 4'd0 : digs[key] + 4'd1;
        end else begin
          hit = 1'b1;
          for (int i = 0; i < 3; i++)
            if (digs[i] == DIGIT_BLANK || digs[i] != code_val[i]) hit = 1'b0;
          if (hit) begin
            scr = SCREEN_CTRL;
          end else begin
            n = wrongs + 3'd1;
            // limit of 0 alarms on every wrong entry
            if (n >= limit_val) begin
              alarm = 1'b1;
              n = 3'd0;
            end
            wrongs = n;
          end
          for (int i = 0; i < 3; i++) digs[i] = DIGIT_BLANK;
        end
      end
      SCREEN_CTRL: begin
        if (key == KEY_K1) led = ~led;
        else if (key == KEY_K2) beep = ~beep;
        else if (key == KEY_ENTER) pg = ~pg;
      end
      default: ;
    endcase
    v.screen       = scr;
    v.page         = pg;
    v.led_on       = led;
    v.beeper_on    = beep;
    v.digit_first  = digs[0];
    v.digit_second = digs[1];
    v.digit_third  = digs[2];
    v.alarm_pulse  = alarm;
    v.error_count  = wrongs;
    return v;
  endfunction

  function automatic string view_str(input lock_view_t v);
    return $sformatf("scr=%0d page=%0d led=%0d beep=%0d digits=%0d/%0d/%0d alarm=%0d errs=%0d",
                     v.screen, v.page, v.led_on, v.beeper_on, v.digit_first,
                     v.digit_second, v.digit_third, v.alarm_pulse, v.error_count);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic press_key(input logic [1:0] key);
    while ($urandom_range(99) < gap_pct) begin
      key_ch.valid  = 1'b0;
      key_ch.key_id = 2'($urandom);
      @(negedge clk);
    end
    key_ch.valid  = 1'b1;
    key_ch.key_id = key;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    pending_views.push_back(apply_key(key));
    presses++;
    @(negedge clk);
  endtask

  task automatic drain;
    key_ch.valid = 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CODE_FIRST:  code_val[0] = value;
      REG_CODE_SECOND: code_val[1] = value;
      REG_CODE_THIRD:  code_val[2] = value;
      REG_ERROR_LIMIT: limit_val = value[2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_lock(input logic [3:0] c1, input logic [3:0] c2,
                              input logic [3:0] c3, input logic [3:0] lim);
    drain();
    write_reg(REG_CODE_FIRST, c1);
    write_reg(REG_CODE_SECOND, c2);
    write_reg(REG_CODE_THIRD, c3);
    write_reg(REG_ERROR_LIMIT, lim);
    cfg_ch.valid = 1'b0;
  endtask

  // steps each digit toward a goal (often the code), then presses enter
  task automatic code_attempt(input int unsigned hit_pct);
    int unsigned first;
    int unsigned idx;
    int          goal;
    int          steps;
    first = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      idx = (first + i) % 3;
      if ($urandom_range(99) < hit_pct && code_val[idx] <= 4'd9) goal = int'(code_val[idx]);
      else goal = $urandom_range(9);
      if (digs[idx] == DIGIT_BLANK) steps = goal + 1;
      else steps = (goal + 10 - int'(digs[idx])) % 10;
      if ($urandom_range(9) == 0) steps += 10;
      if ($urandom_range(9) == 0) steps = 0;
      repeat (steps) press_key(digit_key[idx]);
    end
    press_key(KEY_ENTER);
  endtask

  task automatic key_noise;
    repeat ($urandom_range(1, 6)) press_key(2'($urandom));
  endtask

  task automatic code_screen_run(input int unsigned count);
    int unsigned stop_at;
    stop_at = presses + count;
    while (presses < stop_at)
      if ($urandom_range(99) < 75) code_attempt(50);
      else key_noise();
  endtask

  task automatic test_splash_screen;
    press_key(KEY_K1);
    press_key(KEY_K2);
    press_key(KEY_K3);
    press_key(KEY_ENTER);
  endtask

  task automatic test_wrong_entries;
    // default limit 3: third wrong entry alarms and clears the count
    repeat (3) press_key(KEY_ENTER);
  endtask

  task automatic test_blank_and_wrap;
    // code of blanks must not match blank digits
    program_lock(DIGIT_BLANK, DIGIT_BLANK, DIGIT_BLANK, 4'd3);
    press_key(KEY_ENTER);
    repeat (11) press_key(KEY_K1);
    press_key(KEY_K2);
    press_key(KEY_K3);
    press_key(KEY_ENTER);
  endtask

  task automatic test_locked_entry;
    gap_pct = 18; stall_pct = 71;
    program_lock(4'd9, 4'd0, 4'd15, 4'd7);
    code_screen_run(250);
    // limit below the current count
    program_lock(4'd4, 4'd9, 4'd12, 4'd1);
    code_screen_run(150);
    gap_pct = 71; stall_pct = 18;
    // bit 3 of the limit is dropped, so this is a limit of 0
    program_lock(4'd0, 4'd15, 4'd3, 4'd8);
    code_screen_run(200);
    program_lock(4'd7, 4'd5, 4'd11, 4'd2);
    code_screen_run(150);
  endtask

  task automatic test_unlock_and_control;
    gap_pct = 0; stall_pct = 0;
    program_lock(4'($urandom_range(9)), 4'($urandom_range(9)), 4'($urandom_range(9)),
                 4'($urandom_range(1, 7)));
    while (scr != SCREEN_CTRL) code_attempt(60);
    press_key(KEY_K3);
    press_key(KEY_K1);
    press_key(KEY_K2);
    press_key(KEY_ENTER);
    press_key(KEY_ENTER);
    while (presses < TOTAL_PRESSES) press_key(2'($urandom));
  endtask

  always @(negedge clk) res_ch.ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_results
    lock_view_t seen;
    lock_view_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.screen       = res_ch.screen;
      seen.page         = res_ch.page;
      seen.led_on       = res_ch.led_on;
      seen.beeper_on    = res_ch.beeper_on;
      seen.digit_first  = res_ch.digit_first;
      seen.digit_second = res_ch.digit_second;
      seen.digit_third  = res_ch.digit_third;
      seen.alarm_pulse  = res_ch.alarm_pulse;
      seen.error_count  = res_ch.error_count;
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no request: %s", $realtime, view_str(seen));
      end else begin
        want = pending_views.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected %s", $realtime, view_str(want));
            $display("%0t: actual   %s", $realtime, view_str(seen));
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    key_ch.valid  = 1'b0;
    key_ch.key_id = KEY_K1;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_CODE_FIRST;
    cfg_ch.data   = 4'd0;
    gap_pct    = 18;
    stall_pct  = 71;
    mismatches = 0;
    presses    = 0;
    code_val[0] = 4'd1;
    code_val[1] = 4'd2;
    code_val[2] = 4'd3;
    limit_val   = 3'd3;
    scr  = SCREEN_SPLASH;
    pg   = 1'b0;
    led  = 1'b0;
    beep = 1'b0;
    wrongs = 3'd0;
    for (int i = 0; i < 3; i++) digs[i] = DIGIT_BLANK;
    digit_key[0] = KEY_K1;
    digit_key[1] = KEY_K2;
    digit_key[2] = KEY_K3;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_splash_screen();
    test_wrong_entries();
    test_blank_and_wrap();
    test_locked_entry();
    test_unlock_and_control();

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
